>>> hw/rtl/mld_pkg.sv
// Types, codes and the Morse tree ROM shared by the Morse light decoder.
package mld_pkg;

	localparam int SAMPLE_W    = 10;
	localparam int THRESH_W    = 10;
	localparam int DOT_W       = 13;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 2;
	localparam int TREE_W      = 7;
	localparam int KIND_W      = 2;
	localparam int CHAR_W      = 7;

	localparam logic [TREE_W:0]      TREE_SIZE      = 8'd127;
	localparam logic [THRESH_W-1:0]  THRESH_RESET   = 10'd10;
	localparam logic [DOT_W-1:0]     DOT_RESET      = 13'd400;

	localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DOT_LENGTH      = 2'd1;

	localparam logic [KIND_W-1:0] KIND_DOT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DASH = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CHAR = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] char_code;
	} result_t;

	function automatic logic [CHAR_W-1:0] morse_char(input logic [TREE_W-1:0] idx);
		logic [CHAR_W-1:0] c;
		case (idx)
			7'd1:   c = 7'h45; // E
			7'd2:   c = 7'h54; // T
			7'd3:   c = 7'h49; // I
			7'd4:   c = 7'h41; // A
			7'd5:   c = 7'h4E; // N
			7'd6:   c = 7'h4D; // M
			7'd7:   c = 7'h53; // S
			7'd8:   c = 7'h55; // U
			7'd9:   c = 7'h52; // R
			7'd10:  c = 7'h57; // W
			7'd11:  c = 7'h44; // D
			7'd12:  c = 7'h4B; // K
			7'd13:  c = 7'h47; // G
			7'd14:  c = 7'h4F; // O
			7'd15:  c = 7'h48; // H
			7'd16:  c = 7'h56; // V
			7'd17:  c = 7'h46; // F
			7'd18:  c = 7'h55; // U
			7'd19:  c = 7'h4C; // L
			7'd20:  c = 7'h41; // A
			7'd21:  c = 7'h50; // P
			7'd22:  c = 7'h4A; // J
			7'd23:  c = 7'h42; // B
			7'd24:  c = 7'h58; // X
			7'd25:  c = 7'h43; // C
			7'd26:  c = 7'h59; // Y
			7'd27:  c = 7'h5A; // Z
			7'd28:  c = 7'h51; // Q
			7'd31:  c = 7'h35; // 5
			7'd32:  c = 7'h34; // 4
			7'd34:  c = 7'h33; // 3
			7'd38:  c = 7'h32; // 2
			7'd41:  c = 7'h2B; // +
			7'd46:  c = 7'h31; // 1
			7'd47:  c = 7'h36; // 6
			7'd48:  c = 7'h3D; // =
			7'd49:  c = 7'h2F; // /
			7'd53:  c = 7'h28; // (
			7'd55:  c = 7'h37; // 7
			7'd59:  c = 7'h38; // 8
			7'd61:  c = 7'h39; // 9
			7'd62:  c = 7'h30; // 0
			7'd75:  c = 7'h3F; // ?
			7'd76:  c = 7'h5F; // _
			7'd81:  c = 7'h22; // "
			7'd84:  c = 7'h2E; // .
			7'd89:  c = 7'h40; // @
			7'd96:  c = 7'h2D; // -
			7'd105: c = 7'h3B; // ;
			7'd106: c = 7'h21; // !
			7'd108: c = 7'h29; // )
			7'd114: c = 7'h2C; // ,
			7'd119: c = 7'h3A; // :
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage

>>> hw/rtl/mld_stream_if.sv
// Valid/ready channel interfaces for samples and decoded results.
interface mld_sample_if import mld_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface mld_result_if import mld_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [CHAR_W-1:0] char_code;

	modport source (output valid, output kind, output char_code, input ready);
	modport sink   (input valid, input kind, input char_code, output ready);
endinterface

>>> hw/rtl/morse_light_decoder.sv
// Morse light decoder top level: run counters, tree walk and result buffering.
// Each result is registered into the result buffer and offered on the result channel from there.
// Throughput: one sample per cycle; the two-entry result buffer holds up to two results
// while the result side stalls, and samples are refused only when it is full.
// Reset: arst_n clears run counters, tree index, overflow mark and the buffer, and
// loads light_threshold 10 and dot_length 400.
module morse_light_decoder import mld_pkg::*; #(
	parameter int COUNT_WIDTH = 14
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	mld_sample_if.sink             samples,
	mld_result_if.source           results
);

	localparam int CMP_W = (COUNT_WIDTH > DOT_W + 1) ? COUNT_WIDTH : DOT_W + 1;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [THRESH_W-1:0]    thresh_q;
	logic [DOT_W-1:0]       dot_q;
	logic [COUNT_WIDTH-1:0] on_run_q;
	logic [COUNT_WIDTH-1:0] off_run_q;
	logic [TREE_W-1:0]      tree_idx_q;
	logic                   ovf_q;

	logic                   accept;
	logic                   buf_full;
	logic                   light_on;
	logic [COUNT_WIDTH-1:0] off_inc;
	logic [CMP_W-1:0]       on_ext;
	logic [CMP_W-1:0]       off_inc_ext;
	logic [CMP_W-1:0]       dot_ext;
	logic [CMP_W-1:0]       two_ext;
	logic                   is_dot;
	logic                   is_dash;
	logic                   char_end;
	logic [TREE_W:0]        next_idx;
	logic                   sym_ovf;
	logic                   emit;
	result_t                res;

	assign samples.ready = !buf_full;
	assign accept        = samples.valid && samples.ready;

	assign light_on    = (samples.sample <= thresh_q);
	assign off_inc     = (off_run_q == COUNT_MAX) ? COUNT_MAX : off_run_q + 1'b1;
	assign on_ext      = CMP_W'(on_run_q);
	assign off_inc_ext = CMP_W'(off_inc);
	assign dot_ext     = CMP_W'(dot_q);
	assign two_ext     = CMP_W'({dot_q, 1'b0});

	assign is_dot   = (on_ext >= dot_ext) && (on_ext < two_ext);
	assign is_dash  = (on_ext >= two_ext);
	assign char_end = (off_inc_ext == two_ext) && ((tree_idx_q != '0) || ovf_q);

	assign next_idx = {tree_idx_q, 1'b0} + (is_dash ? 8'd2 : 8'd1);
	assign sym_ovf  = ovf_q || (next_idx >= TREE_SIZE);

	assign emit = accept && !light_on && (is_dot || is_dash || char_end);

	always_comb begin
		res.kind      = KIND_DOT;
		res.char_code = '0;
		if (is_dash) begin
			res.kind = KIND_DASH;
		end else if (!is_dot) begin
			res.kind      = KIND_CHAR;
			res.char_code = ovf_q ? '0 : morse_char(tree_idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
			dot_q    <= DOT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LIGHT_THRESHOLD: thresh_q <= cfg_data[THRESH_W-1:0];
				REG_DOT_LENGTH:      dot_q    <= cfg_data[DOT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_run_q   <= '0;
			off_run_q  <= '0;
			tree_idx_q <= '0;
			ovf_q      <= 1'b0;
		end else if (accept) begin
			if (light_on) begin
				on_run_q  <= (on_run_q == COUNT_MAX) ? COUNT_MAX : on_run_q + 1'b1;
				off_run_q <= '0;
			end else begin
				on_run_q  <= '0;
				off_run_q <= off_inc;
				if (is_dot || is_dash) begin
					if (sym_ovf) begin
						ovf_q <= 1'b1;
					end else begin
						tree_idx_q <= next_idx[TREE_W-1:0];
					end
				end else if (char_end) begin
					tree_idx_q <= '0;
					ovf_q      <= 1'b0;
				end
			end
		end
	end

	mld_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (res),
		.full      (buf_full),
		.results   (results)
	);

	a_idx_in_tree: assert property (@(posedge clk) disable iff (!arst_n)
		tree_idx_q != 7'd127)
		else $error("tree index left the tree");

	a_char_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && res.kind == KIND_CHAR) |=> (tree_idx_q == '0 && !ovf_q))
		else $error("character end did not return to root");

	a_light_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && light_on) |=> ($stable(tree_idx_q) && off_run_q == '0))
		else $error("light-on sample moved the tree or kept the dark run");

	a_ovf_holds_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ovf_q && !light_on && (is_dot || is_dash)) |=> $stable(tree_idx_q))
		else $error("tree index moved during overflow");

endmodule

>>> hw/rtl/mld_out_buf.sv
// Two-entry result buffer that decouples the decoder from the result channel.
module mld_out_buf import mld_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	mld_result_if.source results
);

	result_t     slot0_q;
	result_t     slot1_q;
	logic [1:0]  count_q;
	logic        pop;

	assign pop               = results.valid && results.ready;
	assign full              = (count_q == 2'd2);
	assign results.valid     = (count_q != 2'd0);
	assign results.kind      = slot0_q.kind;
	assign results.char_code = slot0_q.char_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && push) begin
			if (count_q == 2'd1) begin
				slot0_q <= push_data;
			end else begin
				slot0_q <= slot1_q;
				slot1_q <= push_data;
			end
		end else if (pop) begin
			slot0_q <= slot1_q;
		end else if (push) begin
			if (count_q == 2'd0) begin
				slot0_q <= push_data;
			end else begin
				slot1_q <= push_data;
			end
		end
	end

endmodule
